// ----- sv/tlsm_pkg.sv -----
`default_nettype none

package tlsm_pkg;

    localparam int NODE_COUNT    = 4096;
    localparam int ALPHABET_SIZE = 26;
    localparam int NODE_W        = $clog2(NODE_COUNT);
    localparam int FREE_W        = NODE_W + 1;
    localparam int LETTER_W      = 5;
    localparam int IDX_W         = 16;
    localparam int LEN_W         = 16;
    localparam int BEST_W        = IDX_W + LEN_W;
    localparam int ROW_W         = ALPHABET_SIZE * NODE_W;

    typedef logic [ALPHABET_SIZE-1:0][NODE_W-1:0] row_t;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_QUERY  = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINK,
        ST_ZERO,
        ST_BEST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic ready;
        logic accept;
        logic stop;
        logic overflow;
        logic alloc;
        logic follow;
        logic zero_row;
        logic best_update;
        logic take_answer;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic item_valid;
        logic is_query;
        logic is_last;
        logic stopped;
        logic letter_bad;
        logic link_zero;
        logic table_full;
        logic shorter;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// ----- sv/tlsm_item_if.sv -----
`default_nettype none

interface tlsm_item_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [tlsm_pkg::LETTER_W-1:0] letter;
    logic                          first_letter;
    logic                          last_letter;
    logic [tlsm_pkg::IDX_W-1:0]    word_index;
    logic [tlsm_pkg::LEN_W-1:0]    word_length;

    modport source (
        output valid, mode, letter, first_letter, last_letter, word_index, word_length,
        input  ready
    );

    modport sink (
        input  valid, mode, letter, first_letter, last_letter, word_index, word_length,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/tlsm_result_if.sv -----
`default_nettype none

interface tlsm_result_if;
    logic                       valid;
    logic                       ready;
    logic [tlsm_pkg::IDX_W-1:0] answer_index;
    logic                       table_overflowed;

    modport source (
        output valid, answer_index, table_overflowed,
        input  ready
    );

    modport sink (
        input  valid, answer_index, table_overflowed,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/tlsm_ram.sv -----
`default_nettype none

module tlsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/tlsm_ctrl.sv -----
`default_nettype none

module tlsm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tlsm_pkg::status_t status,
    output tlsm_pkg::cmd_t         cmd
);

    tlsm_pkg::state_t state_reg;
    tlsm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlsm_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlsm_pkg::ST_CLEAR:
            begin
                state_next = tlsm_pkg::ST_IDLE;
            end
            tlsm_pkg::ST_IDLE:
            begin
                if (status.item_valid)
                begin
                    state_next = tlsm_pkg::ST_LINK;
                end
            end
            tlsm_pkg::ST_LINK:
            begin
                if (status.stopped || status.letter_bad)
                begin
                    state_next = tlsm_pkg::ST_DONE;
                end
                else if (!status.link_zero)
                begin
                    state_next = tlsm_pkg::ST_BEST;
                end
                else if (!status.is_query && !status.table_full)
                begin
                    state_next = tlsm_pkg::ST_ZERO;
                end
                else
                begin
                    state_next = tlsm_pkg::ST_DONE;
                end
            end
            tlsm_pkg::ST_ZERO:
            begin
                state_next = tlsm_pkg::ST_DONE;
            end
            tlsm_pkg::ST_BEST:
            begin
                state_next = tlsm_pkg::ST_DONE;
            end
            tlsm_pkg::ST_DONE:
            begin
                if (!(status.is_query && status.is_last) || !status.out_busy)
                begin
                    state_next = tlsm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            tlsm_pkg::ST_CLEAR:
            begin
                cmd.zero_row = 1'b1;
            end
            tlsm_pkg::ST_IDLE:
            begin
                cmd.ready  = 1'b1;
                cmd.accept = status.item_valid;
            end
            tlsm_pkg::ST_LINK:
            begin
                if (status.stopped || status.letter_bad)
                begin
                    cmd.stop = 1'b1;
                end
                else if (!status.link_zero)
                begin
                    cmd.follow = 1'b1;
                end
                else if (status.is_query)
                begin
                    cmd.stop = 1'b1;
                end
                else if (status.table_full)
                begin
                    cmd.stop     = 1'b1;
                    cmd.overflow = 1'b1;
                end
                else
                begin
                    cmd.alloc = 1'b1;
                end
            end
            tlsm_pkg::ST_ZERO:
            begin
                cmd.zero_row = 1'b1;
            end
            tlsm_pkg::ST_BEST:
            begin
                cmd.take_answer = status.is_query;
                cmd.best_update = !status.is_query && status.shorter;
            end
            tlsm_pkg::ST_DONE:
            begin
                cmd.emit = status.is_query && status.is_last && !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/tlsm_datapath.sv -----
`default_nettype none

module tlsm_datapath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    tlsm_item_if.sink           items,
    tlsm_result_if.source       results,
    input  wire tlsm_pkg::cmd_t cmd,
    output tlsm_pkg::status_t   status
);

    logic                          mode_reg;
    logic [tlsm_pkg::LETTER_W-1:0] letter_reg;
    logic                          last_reg;
    logic [tlsm_pkg::IDX_W-1:0]    idx_reg;
    logic [tlsm_pkg::LEN_W-1:0]    len_reg;

    logic [tlsm_pkg::NODE_W-1:0]   cursor_reg;
    logic [tlsm_pkg::NODE_W-1:0]   cursor_next;
    logic [tlsm_pkg::FREE_W-1:0]   next_free_reg;
    logic                          stopped_reg;
    logic [tlsm_pkg::IDX_W-1:0]    held_reg;
    logic                          overflow_reg;
    logic                          root_filled_reg;
    logic [tlsm_pkg::IDX_W-1:0]    root_idx_reg;
    logic [tlsm_pkg::LEN_W-1:0]    root_len_reg;

    logic                          out_valid_reg;
    logic [tlsm_pkg::IDX_W-1:0]    out_index_reg;
    logic                          out_ovf_reg;

    logic                          row_we;
    logic [tlsm_pkg::NODE_W-1:0]   row_addr;
    tlsm_pkg::row_t                row_q;
    tlsm_pkg::row_t                row_new;
    tlsm_pkg::row_t                row_wdata;
    logic [tlsm_pkg::ROW_W-1:0]    row_q_bits;

    logic                          best_we;
    logic [tlsm_pkg::NODE_W-1:0]   best_addr;
    logic [tlsm_pkg::BEST_W-1:0]   best_q;

    logic                          letter_bad;
    logic [tlsm_pkg::NODE_W-1:0]   link;
    logic [tlsm_pkg::NODE_W-1:0]   new_node;

    assign letter_bad = letter_reg >= tlsm_pkg::LETTER_W'(tlsm_pkg::ALPHABET_SIZE);
    assign row_q      = tlsm_pkg::row_t'(row_q_bits);
    assign link       = letter_bad ? '0 : row_q[letter_reg];
    assign new_node   = next_free_reg[tlsm_pkg::NODE_W-1:0];

    always_comb
    begin
        row_new = row_q;
        if (!letter_bad)
        begin
            row_new[letter_reg] = new_node;
        end
    end

    assign cursor_next = items.first_letter ? '0 : cursor_reg;

    always_comb
    begin
        if (cmd.accept)
        begin
            row_addr = cursor_next;
        end
        else
        begin
            row_addr = cursor_reg;
        end
        row_we    = cmd.alloc || cmd.zero_row;
        row_wdata = cmd.zero_row ? '0 : row_new;
    end

    always_comb
    begin
        if (cmd.alloc)
        begin
            best_addr = new_node;
        end
        else if (cmd.follow)
        begin
            best_addr = link;
        end
        else
        begin
            best_addr = cursor_reg;
        end
        best_we = cmd.alloc || cmd.best_update;
    end

    tlsm_ram #(
        .WIDTH(tlsm_pkg::ROW_W),
        .DEPTH(tlsm_pkg::NODE_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (row_we),
        .addr  (row_addr),
        .wdata (tlsm_pkg::ROW_W'(row_wdata)),
        .rdata (row_q_bits)
    );

    tlsm_ram #(
        .WIDTH(tlsm_pkg::BEST_W),
        .DEPTH(tlsm_pkg::NODE_COUNT)
    ) u_best_ram (
        .clk   (clk),
        .we    (best_we),
        .addr  (best_addr),
        .wdata ({idx_reg, len_reg}),
        .rdata (best_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg   <= items.mode;
            letter_reg <= items.letter;
            last_reg   <= items.last_letter;
            idx_reg    <= items.word_index;
            len_reg    <= items.word_length;
        end
        if (cmd.accept && items.first_letter && (items.mode == tlsm_pkg::MODE_INSERT))
        begin
            if (!root_filled_reg || (items.word_length < root_len_reg))
            begin
                root_idx_reg <= items.word_index;
                root_len_reg <= items.word_length;
            end
        end
        if (cmd.emit)
        begin
            out_index_reg <= held_reg;
            out_ovf_reg   <= overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg      <= '0;
            next_free_reg   <= tlsm_pkg::FREE_W'(1);
            stopped_reg     <= 1'b0;
            held_reg        <= '0;
            overflow_reg    <= 1'b0;
            root_filled_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                cursor_reg <= cursor_next;
                if (items.first_letter)
                begin
                    stopped_reg <= 1'b0;
                    if (items.mode == tlsm_pkg::MODE_QUERY)
                    begin
                        held_reg <= root_filled_reg ? root_idx_reg : '0;
                    end
                    else
                    begin
                        root_filled_reg <= 1'b1;
                    end
                end
            end
            if (cmd.stop)
            begin
                stopped_reg <= 1'b1;
            end
            if (cmd.overflow)
            begin
                overflow_reg <= 1'b1;
            end
            if (cmd.alloc)
            begin
                cursor_reg    <= new_node;
                next_free_reg <= next_free_reg + tlsm_pkg::FREE_W'(1);
            end
            if (cmd.follow)
            begin
                cursor_reg <= link;
            end
            if (cmd.take_answer)
            begin
                held_reg <= best_q[tlsm_pkg::BEST_W-1:tlsm_pkg::LEN_W];
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign items.ready              = cmd.ready;
    assign results.valid            = out_valid_reg;
    assign results.answer_index     = out_index_reg;
    assign results.table_overflowed = out_ovf_reg;

    always_comb
    begin
        status.item_valid = items.valid;
        status.is_query   = mode_reg == tlsm_pkg::MODE_QUERY;
        status.is_last    = last_reg;
        status.stopped    = stopped_reg;
        status.letter_bad = letter_bad;
        status.link_zero  = link == '0;
        status.table_full = next_free_reg >= tlsm_pkg::FREE_W'(tlsm_pkg::NODE_COUNT);
        status.shorter    = len_reg < best_q[tlsm_pkg::LEN_W-1:0];
        status.out_busy   = out_valid_reg && !results.ready;
    end

endmodule

`default_nettype wire

// ----- sv/trie_longest_suffix_match.sv -----
`default_nettype none

// Suffix trie matcher. Words arrive one letter per beat on the item channel,
// last letter first; a query beat marked as the word's final letter yields one
// result beat with the kept index of the deepest node reached and the sticky
// overflow flag. Each beat goes through these steps: accept it and start
// reading the child row from the single-port link table, pick the child
// link and allocate or follow, then the node-data read or the clearing of
// the row of a new node when the walk goes on, and a last step to finish,
// which may wait while an earlier result beat has not been taken.
// After reset the block clears the root row in its clear state before it
// accepts its first beat.
module trie_longest_suffix_match (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tlsm_item_if.sink     items,
    tlsm_result_if.source results
);

    tlsm_pkg::cmd_t    cmd;
    tlsm_pkg::status_t status;

    tlsm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    tlsm_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int RANDOM_BEATS    = 1650;
    localparam int PHASE_BEATS     = 120;

    localparam int SENDER_IDLE_PCT [4]   = '{0, 71, 0, 10};
    localparam int RECEIVER_STALL_PCT [4] = '{0, 0, 71, 10};

    typedef struct {
        tlsm_pkg::mode_t                     mode;
        logic [tlsm_pkg::LETTER_W-1:0]       letter;
        bit                                  first_letter;
        bit                                  last_letter;
        logic [tlsm_pkg::IDX_W-1:0]          word_index;
        logic [tlsm_pkg::LEN_W-1:0]          word_length;
    } letter_beat_t;

    typedef struct packed {
        logic [tlsm_pkg::IDX_W-1:0] answer_index;
        logic                       table_overflowed;
    } match_t;

    typedef struct {
        tlsm_pkg::mode_t  mode;
        int               letter;
        bit               first_letter;
        bit               last_letter;
        int               word_index;
        int               word_length;
        bit               pinned;
        int               pinned_answer;
        bit               pinned_overflow;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 21;

    directed_row_t directed_table [DIRECTED_ROWS] = '{
        '{tlsm_pkg::MODE_QUERY,   0, 1'b1, 1'b1,     0,     1, 1'b1, 0, 1'b0},
        '{tlsm_pkg::MODE_QUERY,  31, 1'b1, 1'b1,     0,     1, 1'b1, 0, 1'b0},
        '{tlsm_pkg::MODE_INSERT,  1, 1'b1, 1'b0,     7,     2, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_INSERT,  0, 1'b0, 1'b1,     7,     2, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_QUERY,   1, 1'b1, 1'b1,     0,     1, 1'b1, 7, 1'b0},
        '{tlsm_pkg::MODE_INSERT,  1, 1'b1, 1'b1, 65535, 65535, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_INSERT, 25, 1'b1, 1'b1,     0,     1, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_QUERY,  16, 1'b1, 1'b1,     0,     1, 1'b1, 0, 1'b0},
        '{tlsm_pkg::MODE_INSERT,  1, 1'b1, 1'b0,   300,     0, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_INSERT,  2, 1'b0, 1'b1,   300,     0, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_QUERY,   1, 1'b1, 1'b0,     0,     1, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_QUERY,   2, 1'b0, 1'b1,     0,     1, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_INSERT, 26, 1'b1, 1'b0,     5,     1, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_INSERT,  3, 1'b0, 1'b1,     5,     1, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_QUERY,  26, 1'b1, 1'b1,     0,     1, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_QUERY,   1, 1'b1, 1'b0,     0,     1, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_INSERT,  4, 1'b0, 1'b1,     9,     3, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_QUERY,   4, 1'b0, 1'b1,     0,     1, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_QUERY,  31, 1'b0, 1'b1, 65535, 65535, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_INSERT, 31, 1'b1, 1'b1, 65535,     1, 1'b0, 0, 1'b0},
        '{tlsm_pkg::MODE_QUERY,  25, 1'b1, 1'b1,     0,     1, 1'b0, 0, 1'b0}
    };

    logic clk;
    logic rst_n;

    tlsm_item_if   item_bus ();
    tlsm_result_if match_bus ();

    trie_longest_suffix_match u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_bus),
        .results (match_bus)
    );

    bit [tlsm_pkg::NODE_W-1:0] trie_child [tlsm_pkg::NODE_COUNT*tlsm_pkg::ALPHABET_SIZE];
    bit [tlsm_pkg::IDX_W-1:0]  kept_index [tlsm_pkg::NODE_COUNT];
    bit [tlsm_pkg::LEN_W-1:0]  kept_length [tlsm_pkg::NODE_COUNT];
    bit                        root_used;
    int unsigned               walk_node;
    int unsigned               free_node = 1;
    bit                        walk_halted;
    bit [tlsm_pkg::IDX_W-1:0]  walk_answer;
    bit                        overflow_seen;

    match_t pending_matches [$];
    int     mismatch_count;
    int     beats_sent;
    int     sender_idle_pct;
    int     receiver_stall_pct;
    bit     hold_off_request;
    int     quiet_cycles;

    function automatic void keep_shorter(input int unsigned node,
                                         input bit [tlsm_pkg::IDX_W-1:0] idx,
                                         input bit [tlsm_pkg::LEN_W-1:0] len);
        if (len < kept_length[node])
        begin
            kept_index[node]  = idx;
            kept_length[node] = len;
        end
    endfunction

    function automatic bit predict_match(input letter_beat_t b, output match_t m);
        int unsigned slot;
        int unsigned child;
        m = '0;
        if (b.first_letter)
        begin
            walk_node   = 0;
            walk_halted = 1'b0;
            if (b.mode == tlsm_pkg::MODE_QUERY)
                walk_answer = root_used ? kept_index[0] : '0;
            else if (!root_used)
            begin
                root_used      = 1'b1;
                kept_index[0]  = b.word_index;
                kept_length[0] = b.word_length;
            end
            else
                keep_shorter(0, b.word_index, b.word_length);
        end
        if (!walk_halted)
        begin
            if (b.letter >= tlsm_pkg::ALPHABET_SIZE)
                walk_halted = 1'b1;
            else
            begin
                slot  = walk_node * tlsm_pkg::ALPHABET_SIZE + b.letter;
                child = trie_child[slot];
                if (child != 0)
                begin
                    walk_node = child;
                    if (b.mode == tlsm_pkg::MODE_QUERY)
                        walk_answer = kept_index[child];
                    else
                        keep_shorter(child, b.word_index, b.word_length);
                end
                else if (b.mode == tlsm_pkg::MODE_QUERY)
                    walk_halted = 1'b1;
                else if (free_node >= tlsm_pkg::NODE_COUNT)
                begin
                    overflow_seen = 1'b1;
                    walk_halted   = 1'b1;
                end
                else
                begin
                    trie_child[slot]       = free_node[tlsm_pkg::NODE_W-1:0];
                    kept_index[free_node]  = b.word_index;
                    kept_length[free_node] = b.word_length;
                    walk_node              = free_node;
                    free_node++;
                end
            end
        end
        if (b.mode == tlsm_pkg::MODE_INSERT || !b.last_letter)
            return 1'b0;
        m.answer_index     = walk_answer;
        m.table_overflowed = overflow_seen;
        return 1'b1;
    endfunction

    task automatic send_beat(input letter_beat_t b, input bit pinned, input match_t pinned_match);
        match_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid        <= 1'b1;
        item_bus.mode         <= b.mode;
        item_bus.letter       <= b.letter;
        item_bus.first_letter <= b.first_letter;
        item_bus.last_letter  <= b.last_letter;
        item_bus.word_index   <= b.word_index;
        item_bus.word_length  <= b.word_length;
        do
            @(posedge clk);
        while (!item_bus.ready);
        if (predict_match(b, predicted))
            pending_matches.push_back(pinned ? pinned_match : predicted);
        beats_sent++;
    endtask

    task automatic send_word(input tlsm_pkg::mode_t mode, input int letters,
                             input int letter_hi, input int odd_pct);
        letter_beat_t b;
        int pick;
        b.mode        = mode;
        b.word_index  = tlsm_pkg::IDX_W'($urandom);
        b.word_length = ($urandom_range(99) < 80) ? tlsm_pkg::LEN_W'($urandom_range(0, 8))
                                                  : tlsm_pkg::LEN_W'($urandom);
        for (int i = 0; i < letters; i++)
        begin
            pick = $urandom_range(99);
            if (pick < odd_pct)
                b.letter = tlsm_pkg::LETTER_W'($urandom_range(tlsm_pkg::ALPHABET_SIZE, 31));
            else if (pick < 10)
                b.letter = tlsm_pkg::LETTER_W'($urandom_range(0, tlsm_pkg::ALPHABET_SIZE - 1));
            else
                b.letter = tlsm_pkg::LETTER_W'($urandom_range(0, letter_hi));
            b.first_letter = (i == 0) && ($urandom_range(99) >= odd_pct);
            b.last_letter  = (i == letters - 1);
            send_beat(b, 1'b0, '0);
        end
    endtask

    task automatic run_random(input int beat_count);
        letter_beat_t noise;
        int stop_at;
        int phase;
        stop_at = beats_sent + beat_count;
        while (beats_sent < stop_at)
        begin
            phase              = (beats_sent / PHASE_BEATS) % 4;
            sender_idle_pct    = SENDER_IDLE_PCT[phase];
            receiver_stall_pct = RECEIVER_STALL_PCT[phase];
            if ($urandom_range(99) < 10)
            begin
                noise.mode         = tlsm_pkg::mode_t'($urandom_range(1));
                noise.letter       = tlsm_pkg::LETTER_W'($urandom_range(31));
                noise.first_letter = 1'($urandom_range(1));
                noise.last_letter  = 1'($urandom_range(1));
                noise.word_index   = tlsm_pkg::IDX_W'($urandom);
                noise.word_length  = tlsm_pkg::LEN_W'($urandom);
                send_beat(noise, 1'b0, '0);
            end
            else
                send_word(($urandom_range(99) < 45) ? tlsm_pkg::MODE_QUERY
                                                    : tlsm_pkg::MODE_INSERT,
                          $urandom_range(1, 6), 3, 3);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        match_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                match_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
                match_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        match_t want;
        if (rst_n && match_bus.valid && match_bus.ready)
        begin
            if (pending_matches.size() == 0)
            begin
                $error("Unexpected result beat: answer_index %0d, table_overflowed %0d",
                       match_bus.answer_index, match_bus.table_overflowed);
                mismatch_count++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (match_bus.answer_index !== want.answer_index)
                begin
                    $error("answer_index: expected %0d, actual %0d",
                           want.answer_index, match_bus.answer_index);
                    mismatch_count++;
                end
                if (match_bus.table_overflowed !== want.table_overflowed)
                begin
                    $error("table_overflowed: expected %0d, actual %0d",
                           want.table_overflowed, match_bus.table_overflowed);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (match_bus.valid && match_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        letter_beat_t b;
        match_t       pinned_match;
        rst_n                 <= 1'b0;
        item_bus.valid        <= 1'b0;
        item_bus.mode         <= tlsm_pkg::MODE_INSERT;
        item_bus.letter       <= '0;
        item_bus.first_letter <= 1'b0;
        item_bus.last_letter  <= 1'b0;
        item_bus.word_index   <= '0;
        item_bus.word_length  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            b.mode                        = directed_table[r].mode;
            b.letter                      = tlsm_pkg::LETTER_W'(directed_table[r].letter);
            b.first_letter                = directed_table[r].first_letter;
            b.last_letter                 = directed_table[r].last_letter;
            b.word_index                  = tlsm_pkg::IDX_W'(directed_table[r].word_index);
            b.word_length                 = tlsm_pkg::LEN_W'(directed_table[r].word_length);
            pinned_match.answer_index     = tlsm_pkg::IDX_W'(directed_table[r].pinned_answer);
            pinned_match.table_overflowed = directed_table[r].pinned_overflow;
            send_beat(b, directed_table[r].pinned, pinned_match);
        end

        // Results pile up behind a long receiver hold-off until the input stalls.
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_request   = 1'b1;
        repeat (30) send_word(tlsm_pkg::MODE_QUERY, 1, 3, 0);

        run_random(RANDOM_BEATS);

        item_bus.valid     <= 1'b0;
        receiver_stall_pct = 0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
